// File: hdl/utf16_to_utf8_transcoder_top_defines.svh
// Assertion macros used by the checker of the transcoder.
`ifndef UTF16_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define U16U8_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define U16U8_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/u16u8_pkg.sv
// Shared types, constants and the UTF-8 byte builder of the transcoder.
`default_nettype none
package u16u8_pkg;

  // Number of UTF-8 bytes a queued word expands to, minus one.
  typedef enum logic [1:0] {
    KIND_ONE   = 2'd0,
    KIND_TWO   = 2'd1,
    KIND_THREE = 2'd2,
    KIND_FOUR  = 2'd3
  } kind_t;

  // One queued word: a unit or a completed code point and its length.
  typedef struct packed {
    kind_t       kind;
    logic [20:0] value;
  } cmd_t;

  localparam logic [1:0] EncPass    = 2'd0;
  localparam logic [1:0] EncUtf16Le = 2'd1;
  localparam logic [1:0] EncUtf16Be = 2'd2;

  localparam logic [0:0] RegSourceEncoding = 1'b0;

  localparam int QueueDepth = 4;

  localparam logic [20:0] SupplementaryBase = 21'h10000;
  localparam logic [15:0] Limit1Byte        = 16'h0080;
  localparam logic [15:0] Limit2Byte        = 16'h0800;
  localparam logic [4:0]  SurrogateTop      = 5'b11011;

  // Byte number idx of the UTF-8 sequence for a queued word.
  function automatic logic [7:0] utf8_byte_of(input cmd_t c, input logic [1:0] idx);
    logic [1:0] rest;
    logic [5:0] bits;
    logic [7:0] b;
    rest = 2'(c.kind - idx);
    case (rest)
      2'd0:    bits = c.value[5:0];
      2'd1:    bits = c.value[11:6];
      2'd2:    bits = c.value[17:12];
      default: bits = 6'd0;
    endcase
    if (idx != 2'd0) begin
      b = {2'b10, bits};
    end else begin
      case (c.kind)
        KIND_ONE:   b = c.value[7:0];
        KIND_TWO:   b = {3'b110, c.value[10:6]};
        KIND_THREE: b = {4'b1110, c.value[15:12]};
        KIND_FOUR:  b = {5'b11110, c.value[20:18]};
        default:    b = 8'd0;
      endcase
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// File: hdl/utf16_to_utf8_transcoder_top.sv
// Top level of the UTF-16 to UTF-8 transcoder with its register port.
// The transcoder takes one source byte per word on the input queue and gives
// UTF-8 bytes, one per word, on the result queue. The source_encoding register
// (byte address 0) selects pass-through (0, and also 3), UTF-16 little-endian
// (1) or big-endian (2). In UTF-16 modes two bytes make one code unit; a unit
// gives 1, 2 or 3 bytes, a surrogate unit is held and the next unit completes
// a 4-byte sequence. A word with end_of_string set drops any half unit or held
// surrogate once its own bytes are out. run_last marks the final byte that an
// input word caused. The front end accepts an input word every cycle as long
// as its word queue (QUEUE_DEPTH entries) has room; the back end delivers one
// result byte per cycle while words are queued and the receiver pops. In
// pass-through each input word causes one result byte; in UTF-16 modes an
// input byte causes, averaged over a unit, one half to one and a half result
// bytes. A word passes the word queue, the current-word and the output register.
// Write the register only while the block is idle.
`default_nettype none
module utf16_to_utf8_transcoder_top #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input queue side.
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_string,
  // Result queue side.
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       utf8_byte,
  output logic             run_last,
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [1:0]       source_encoding;
  logic             reg_sel;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  u16u8_pkg::cmd_t  q_wr_data;
  u16u8_pkg::cmd_t  q_rd_data;

  // Register i sits at byte address 4*i, so bit 2 carries the index.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == u16u8_pkg::RegSourceEncoding);
  assign prdata  = reg_sel ? {30'd0, source_encoding} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_encoding <= u16u8_pkg::EncPass;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      source_encoding <= pwdata[1:0];
    end
  end

  u16u8_front u_front (
    .clk             (clk),
    .rst             (rst),
    .source_encoding (source_encoding),
    .push            (push),
    .full            (full),
    .data_byte       (data_byte),
    .end_of_string   (end_of_string),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wr_data)
  );

  // The queue lets the front end keep taking bytes while the back end is
  // still spelling out a long sequence.
  u16u8_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .utf8_byte (utf8_byte),
    .run_last  (run_last)
  );

endmodule
`default_nettype wire

// File: hdl/u16u8_front.sv
// Front end: pairs bytes into units, tracks surrogates and queues words.
`default_nettype none
module u16u8_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        source_encoding,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        data_byte,
  input  wire logic              end_of_string,
  input  wire logic              q_full,
  output logic                   q_push,
  output u16u8_pkg::cmd_t        q_data
);

  logic [7:0]  held_first_byte;
  logic        byte_phase;
  logic        surrogate_pending;
  logic [9:0]  high_surrogate_bits;

  logic        accept;
  logic        utf16;
  logic        emit;
  logic        is_surrogate;
  logic [15:0] unit;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign utf16  = (source_encoding == u16u8_pkg::EncUtf16Le) ||
                  (source_encoding == u16u8_pkg::EncUtf16Be);
  assign unit   = (source_encoding == u16u8_pkg::EncUtf16Le) ?
                  {data_byte, held_first_byte} : {held_first_byte, data_byte};
  assign is_surrogate = (unit[15:11] == u16u8_pkg::SurrogateTop);

  always_comb begin
    emit         = 1'b0;
    q_data.kind  = u16u8_pkg::KIND_ONE;
    q_data.value = {13'd0, data_byte};
    if (utf16) begin
      if (byte_phase) begin
        if (surrogate_pending) begin
          emit         = 1'b1;
          q_data.kind  = u16u8_pkg::KIND_FOUR;
          q_data.value = u16u8_pkg::SupplementaryBase +
                         {1'b0, high_surrogate_bits, unit[9:0]};
        end else if (unit < u16u8_pkg::Limit1Byte) begin
          emit         = 1'b1;
          q_data.value = {5'd0, unit};
        end else if (unit < u16u8_pkg::Limit2Byte) begin
          emit         = 1'b1;
          q_data.kind  = u16u8_pkg::KIND_TWO;
          q_data.value = {5'd0, unit};
        end else if (!is_surrogate) begin
          emit         = 1'b1;
          q_data.kind  = u16u8_pkg::KIND_THREE;
          q_data.value = {5'd0, unit};
        end
      end
    end else begin
      emit = 1'b1;
    end
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_first_byte     <= 8'd0;
      byte_phase          <= 1'b0;
      surrogate_pending   <= 1'b0;
      high_surrogate_bits <= 10'd0;
    end else if (accept) begin
      if (end_of_string) begin
        held_first_byte     <= 8'd0;
        byte_phase          <= 1'b0;
        surrogate_pending   <= 1'b0;
        high_surrogate_bits <= 10'd0;
      end else if (utf16) begin
        if (!byte_phase) begin
          held_first_byte <= data_byte;
          byte_phase      <= 1'b1;
        end else begin
          held_first_byte <= 8'd0;
          byte_phase      <= 1'b0;
          if (surrogate_pending) begin
            surrogate_pending   <= 1'b0;
            high_surrogate_bits <= 10'd0;
          end else if (is_surrogate) begin
            surrogate_pending   <= 1'b1;
            high_surrogate_bits <= unit[9:0];
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/u16u8_fifo.sv
// Short register queue of words between front and back end.
`default_nettype none
module u16u8_fifo #(
  parameter int Depth = u16u8_pkg::QueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire u16u8_pkg::cmd_t  wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output u16u8_pkg::cmd_t       rd_data,
  output logic                  empty
);

  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

  u16u8_pkg::cmd_t     entries [Depth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : PtrWidth'(wr_ptr + 1'b1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : PtrWidth'(rd_ptr + 1'b1);
      end
      if (do_wr && !do_rd) begin
        count <= CntWidth'(count + 1'b1);
      end else if (do_rd && !do_wr) begin
        count <= CntWidth'(count - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/u16u8_back.sv
// Back end: expands queued words into UTF-8 bytes, one byte per cycle while the receiver pops.
`default_nettype none
module u16u8_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire u16u8_pkg::cmd_t  q_data,
  output logic                  q_pop,
  output logic                  empty,
  input  wire logic             pop,
  output logic [7:0]            utf8_byte,
  output logic                  run_last
);

  u16u8_pkg::cmd_t cur;
  logic            cur_valid;
  logic [1:0]      idx;
  logic            out_valid;

  logic            out_load;
  logic            cur_last;
  logic            cur_done;

  assign empty    = !out_valid;
  assign cur_last = (idx == cur.kind);
  assign out_load = cur_valid && (!out_valid || pop);
  assign cur_done = out_load && cur_last;
  assign q_pop    = !q_empty && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else if (out_load) begin
        idx <= 2'(idx + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (out_load) begin
      utf8_byte <= u16u8_pkg::utf8_byte_of(cur, idx);
      run_last  <= cur_last;
    end
  end

endmodule
`default_nettype wire

// File: hdl/u16u8_checker.sv
// Port-level checks for the transcoder and the bind that attaches them.
`default_nettype none
`include "utf16_to_utf8_transcoder_top_defines.svh"
module u16u8_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [7:0]  utf8_byte,
  input wire logic        run_last,
  input wire logic [31:0] prdata
);

  `U16U8_ASSERT_NOW(a_empty_after_reset, clk, rst, $past(rst), empty, "result after reset")
  `U16U8_ASSERT_NOW(a_cfg_reset_value, clk, rst, $past(rst), prdata == 32'd0, "register not reset")
  `U16U8_ASSERT_NOW(a_cfg_narrow, clk, rst, 1'b1, prdata[31:2] == 30'd0, "register too wide")
  `U16U8_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(utf8_byte) && $stable(run_last), "stalled result changed")

endmodule

bind utf16_to_utf8_transcoder_top u16u8_checker u_checker (.*);
`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the UTF-16 to UTF-8 transcoder top level.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Encoding code 3 has no name in the package; the block treats it as pass-through.
  localparam logic [1:0] EncPassSpare = 2'd3;
  // Register byte addresses: the encoding register, and one address that maps to nothing.
  localparam logic [2:0] AddrSourceEncoding = {u16u8_pkg::RegSourceEncoding, 2'b00};
  localparam logic [2:0] AddrSpare          = 3'd4;

  // Extra cycles allowed after the last expected word. This covers input words
  // that are still in flight and cause no output.
  localparam int SettleCycles  = 8;
  localparam int HoldOffCycles = 80;
  localparam int MaxGap        = 12;
  localparam int ReportLimit   = 10;
  localparam int PhaseWords    = 42;

  // One expected UTF-8 word on the result side.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } utf8_word_t;

  // Kinds of random UTF-16 code unit.
  typedef enum {UnitAscii, UnitTwo, UnitThree, UnitHigh, UnitLow, UnitAny} unit_kind_t;

  // The class predicts the UTF-8 words for each accepted source byte, queues them,
  // and compares each popped word against the oldest entry in that queue.
  class Utf8Scoreboard;
    logic [1:0] encoding;
    logic [7:0] first_byte;
    logic       unit_half;       // Set while waiting for the second byte of a unit.
    logic       surrogate_held;
    logic [9:0] surrogate_bits;
    utf8_word_t expected_words[$];
    int         mismatches;
    int         words_checked;

    function new();
      encoding      = u16u8_pkg::EncPass;
      mismatches    = 0;
      words_checked = 0;
      clear_units();
    endfunction

    function void clear_units();
      first_byte     = 8'h00;
      unit_half      = 1'b0;
      surrogate_held = 1'b0;
      surrogate_bits = 10'h000;
    endfunction

    function void set_encoding(input logic [1:0] value);
      encoding = value;
    endfunction

    function int outstanding();
      return expected_words.size();
    endfunction

    function void flag(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, exp_v, act_v);
      end
    endfunction

    // Queues the UTF-8 form of one code unit. A surrogate unit is held here,
    // and the unit that follows it completes a four-byte code point.
    function void encode_unit(input logic [15:0] unit);
      logic [7:0]  seq [4];
      logic [20:0] point;
      utf8_word_t  w;
      int          n;
      int          k;
      n = 0;
      if (surrogate_held) begin
        point          = u16u8_pkg::SupplementaryBase + {1'b0, surrogate_bits, unit[9:0]};
        surrogate_held = 1'b0;
        surrogate_bits = 10'h000;
        seq[0] = {5'b11110, point[20:18]};
        seq[1] = {2'b10, point[17:12]};
        seq[2] = {2'b10, point[11:6]};
        seq[3] = {2'b10, point[5:0]};
        n = 4;
      end else if (unit < u16u8_pkg::Limit1Byte) begin
        seq[0] = unit[7:0];
        n = 1;
      end else if (unit < u16u8_pkg::Limit2Byte) begin
        seq[0] = {3'b110, unit[10:6]};
        seq[1] = {2'b10, unit[5:0]};
        n = 2;
      end else if (unit[15:11] != u16u8_pkg::SurrogateTop) begin
        seq[0] = {4'b1110, unit[15:12]};
        seq[1] = {2'b10, unit[11:6]};
        seq[2] = {2'b10, unit[5:0]};
        n = 3;
      end else begin
        surrogate_held = 1'b1;
        surrogate_bits = unit[9:0];
      end
      for (k = 0; k < n; k++) begin
        w.value = seq[k];
        w.last  = (k == n - 1);
        expected_words.push_back(w);
      end
    endfunction

    function void note_input(input logic [7:0] b, input logic eos);
      logic [15:0] unit;
      utf8_word_t  w;
      if (encoding == u16u8_pkg::EncUtf16Le || encoding == u16u8_pkg::EncUtf16Be) begin
        if (!unit_half) begin
          first_byte = b;
          unit_half  = 1'b1;
        end else begin
          unit       = (encoding == u16u8_pkg::EncUtf16Le) ? {b, first_byte} : {first_byte, b};
          unit_half  = 1'b0;
          first_byte = 8'h00;
          encode_unit(unit);
        end
      end else begin
        w.value = b;
        w.last  = 1'b1;
        expected_words.push_back(w);
      end
      if (eos) begin
        clear_units();
      end
    endfunction

    function void check_result(input logic [7:0] b, input logic last);
      utf8_word_t w;
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("%0t: word 0x%0h (run_last %0b) arrived with none expected", $time, b, last);
        end
      end else begin
        w = expected_words.pop_front();
        if (b !== w.value) flag("utf8_byte", 32'(w.value), 32'(b));
        if (last !== w.last) flag("run_last", 32'(w.last), 32'(last));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_string = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  utf8_byte;
  logic        run_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  Utf8Scoreboard sb;

  int burst_left    = 0;
  int words_sent    = 0;
  int full_stalls   = 0;
  int hold_cycles   = 0;
  int settings_seen = 0;

  utf16_to_utf8_transcoder_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .empty         (empty),
    .pop           (pop),
    .utf8_byte     (utf8_byte),
    .run_last      (run_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // The clock period is 10 ns: 5 ns high and 5 ns low.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // This task offers one source byte and returns when the block accepts it. The
  // sender works in bursts. Before each burst it may keep push low for a random
  // gap. Inputs change only on the falling edge, and full is sampled on the
  // rising edge where the word is accepted.
  task automatic send_word(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MaxGap);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        push = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push          = 1'b1;
    data_byte     = b;
    end_of_string = eos;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    sb.note_input(b, eos);
    words_sent++;
  endtask

  // This task stops offering words and waits until every predicted word has been
  // popped. It then lets a few more cycles pass. A byte that causes no output,
  // such as half a unit or a held surrogate, may still be inside the block.
  task automatic wait_idle();
    @(negedge clk);
    push = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // This task is an APB write: a setup cycle, then an access cycle that finishes on pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == AddrSourceEncoding) sb.set_encoding(data[1:0]);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // This task reads the encoding register and compares it with the predicted setting.
  task automatic check_encoding_readback();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = AddrSourceEncoding;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[1:0] !== sb.encoding) begin
      sb.flag("source_encoding readback", 32'(sb.encoding), 32'(prdata[1:0]));
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // The register is changed only while the block is idle. Random upper bits in
  // the write data must be ignored. Sometimes the unused address is also written.
  task automatic select_encoding(input logic [1:0] enc);
    logic [31:0] value;
    wait_idle();
    value      = $urandom();
    value[1:0] = enc;
    write_reg(AddrSourceEncoding, value);
    if ($urandom_range(0, 2) == 0) write_reg(AddrSpare, $urandom());
    check_encoding_readback();
    settings_seen++;
  endtask

  // This task sends one code unit as two bytes, in the byte order of the encoding.
  task automatic send_unit(input logic [1:0] enc, input logic [15:0] u, input logic eos);
    if (enc == u16u8_pkg::EncUtf16Le) begin
      send_word(u[7:0], 1'b0);
      send_word(u[15:8], eos);
    end else begin
      send_word(u[15:8], 1'b0);
      send_word(u[7:0], eos);
    end
  endtask

  function automatic logic [15:0] random_unit(input unit_kind_t kind);
    logic [15:0] u;
    case (kind)
      UnitAscii: u = 16'($urandom_range(16'h007F, 16'h0000));
      UnitTwo:   u = 16'($urandom_range(16'h07FF, 16'h0080));
      UnitThree: begin
        // Pick from the three-byte range and skip over the surrogate block.
        u = 16'($urandom_range(16'hF7FF, 16'h0800));
        if (u >= 16'hD800) u = u + 16'h0800;
      end
      UnitHigh:  u = 16'($urandom_range(16'hDBFF, 16'hD800));
      UnitLow:   u = 16'($urandom_range(16'hDFFF, 16'hDC00));
      default:   u = 16'($urandom_range(16'hFFFF, 16'h0000));
    endcase
    return u;
  endfunction

  // This task sends one UTF-16 string of random content, mostly well formed. A few
  // strings break off after half a unit. The end-of-string mark then falls on
  // that lone byte.
  task automatic send_utf16_string(input logic [1:0] enc);
    int   units;
    int   pick;
    int   i;
    logic truncate;
    logic last;
    units    = $urandom_range(1, 6);
    truncate = ($urandom_range(0, 7) == 0);
    for (i = 0; i < units; i++) begin
      last = (i == units - 1) && !truncate;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        send_unit(enc, random_unit(UnitAscii), last);
      end else if (pick < 5) begin
        send_unit(enc, random_unit(UnitTwo), last);
      end else if (pick < 7) begin
        send_unit(enc, random_unit(UnitThree), last);
      end else if (pick < 9) begin
        send_unit(enc, random_unit(UnitHigh), 1'b0);
        send_unit(enc, random_unit(UnitLow), last);
      end else begin
        send_unit(enc, random_unit(UnitAny), last);
      end
    end
    if (truncate) send_word(8'($urandom_range(255, 0)), 1'b1);
  endtask

  // This task runs one random phase. In the UTF-16 modes most of the traffic is
  // whole strings. The rest is single noise bytes, and these can leave a unit
  // half finished.
  task automatic run_phase(input logic [1:0] enc, input int goal);
    int target;
    target = words_sent + goal;
    while (words_sent < target) begin
      if (enc != u16u8_pkg::EncUtf16Le && enc != u16u8_pkg::EncUtf16Be) begin
        send_word(8'($urandom_range(255, 0)), $urandom_range(0, 5) == 0);
      end else if ($urandom_range(0, 9) == 0) begin
        send_word(8'($urandom_range(255, 0)), $urandom_range(0, 3) == 0);
      end else begin
        send_utf16_string(enc);
      end
    end
  endtask

  // The receiver pops on a pattern of its own, and the pattern changes in turn:
  // always ready, a coin toss, mostly stalled, and a fixed periodic gap. The
  // stimulus can set a hold-off, and this process then counts it down cycle by
  // cycle. During it the word queue backs up and full throttles the sender.
  initial begin
    int rx_cycle;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) sb.check_result(utf8_byte, run_last);
      @(negedge clk);
      rx_cycle++;
      if (rst) begin
        pop = 1'b0;
      end else if (hold_cycles > 0) begin
        pop = 1'b0;
        hold_cycles--;
      end else begin
        case ((rx_cycle / 250) % 4)
          0:       pop = 1'b1;
          1:       pop = 1'($urandom_range(0, 1));
          2:       pop = ($urandom_range(0, 3) == 0);
          default: pop = (rx_cycle % 7) != 3;
        endcase
      end
    end
  end

  // This is a watchdog in case the block hangs.
  initial begin
    #3ms;
    $display("tb NOT OK");
    $finish;
  end

  // Main stimulus: reset, a short directed part, then random phases under several encodings.
  initial begin
    logic [1:0] plan [8];
    int         p;
    plan = '{u16u8_pkg::EncUtf16Le, u16u8_pkg::EncUtf16Be, u16u8_pkg::EncPass,
             u16u8_pkg::EncUtf16Le, u16u8_pkg::EncUtf16Be, EncPassSpare,
             u16u8_pkg::EncUtf16Be, u16u8_pkg::EncUtf16Le};
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Pass-through: extreme byte values go through unchanged.
    select_encoding(u16u8_pkg::EncPass);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hA5, 1'b1);

    // A write to an unused address must not change the encoding.
    wait_idle();
    write_reg(AddrSpare, 32'hFFFF_FFFF);
    check_encoding_readback();

    // Code 3 also acts as pass-through.
    select_encoding(EncPassSpare);
    send_word(8'h5A, 1'b1);

    // Little-endian: the edges of the one-, two- and three-byte ranges.
    select_encoding(u16u8_pkg::EncUtf16Le);
    send_unit(u16u8_pkg::EncUtf16Le, 16'h007F, 1'b0);
    send_unit(u16u8_pkg::EncUtf16Le, 16'h0080, 1'b0);
    send_unit(u16u8_pkg::EncUtf16Le, 16'h07FF, 1'b0);
    send_unit(u16u8_pkg::EncUtf16Le, 16'h0800, 1'b0);
    send_unit(u16u8_pkg::EncUtf16Le, 16'hFFFF, 1'b1);

    // Big-endian: a pair that gives the top code point. Then a lone low
    // surrogate, which is held all the same and completed by the next unit.
    // Then a half unit, dropped at the end of its string. Last, a surrogate
    // that the end-of-string mark drops.
    select_encoding(u16u8_pkg::EncUtf16Be);
    send_unit(u16u8_pkg::EncUtf16Be, 16'hDBFF, 1'b0);
    send_unit(u16u8_pkg::EncUtf16Be, 16'hDFFF, 1'b0);
    send_unit(u16u8_pkg::EncUtf16Be, 16'hDC00, 1'b0);
    send_unit(u16u8_pkg::EncUtf16Be, 16'h0000, 1'b0);
    send_word(8'hD8, 1'b1);
    send_unit(u16u8_pkg::EncUtf16Be, 16'hD800, 1'b1);

    for (p = 0; p < 8; p++) begin
      select_encoding(plan[p]);
      if (p == 3) hold_cycles = HoldOffCycles;
      run_phase(plan[p], PhaseWords);
    end

    wait_idle();
    $display("Sent %0d source bytes under %0d encoding settings; popped %0d UTF-8 words.",
             words_sent, settings_seen, sb.words_checked);
    $display("The sender was held off by full for %0d cycles; %0d mismatches seen.",
             full_stalls, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
